@@ rtl/core/gbdn_pkg.sv @@
// Shared types, constants and codes of the gray blur downscale normalizer.
`default_nettype none
package gbdn_pkg;

	localparam int IN_WIDTH_C   = 128;
	localparam int IN_HEIGHT_C  = 128;
	localparam int OUT_WIDTH_C  = 64;
	localparam int OUT_HEIGHT_C = 64;

	localparam int GW = 24;   // Q16 gray value, at most 255<<16
	localparam int QW = 17;   // quotient bits before saturation
	localparam int KW = 4;    // index over the 4x4 source window

	// correction steps after the reciprocal quotient estimate
	localparam int DIV_STEPS = 1;

	localparam logic [GW-1:0] WR_C = 24'd19595;
	localparam logic [GW-1:0] WG_C = 24'd38470;
	localparam logic [GW-1:0] WB_C = 24'd7471;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_start;
	} pix_t;

	typedef struct packed {
		logic [15:0] feature;
		logic [5:0]  out_col;
		logic [5:0]  out_row;
		logic        row_done;
		logic        frame_done;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic          accept;
		logic          rd_en;
		logic [KW-1:0] rd_idx;
		logic          div_load;
		logic          div_step;
		logic          out_load;
		logic          next_col;
	} cmd_t;

	typedef struct packed {
		logic trigger;
		logic out_free;
		logic last_col;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/core/gbdn_stream_if.sv @@
// Valid/ready stream channel carrying one payload struct.
`default_nettype none
interface gbdn_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/gbdn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gbdn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/gbdn_ctrl.sv @@
// Controller: sequences pixel intake, window reads, division and result hand-off.
`default_nettype none
module gbdn_ctrl
	import gbdn_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pix_valid,
	output logic      pix_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	localparam int CNTW = $clog2((1 << KW) + 1);

	state_t           state_q, state_d;
	logic [CNTW-1:0]  cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		pix_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pix_ready  = 1'b1;
				cmd.accept = pix_valid;
				if (pix_valid && sts.trigger) begin
					state_d = ST_READ;
					cnt_d   = '0;
				end
			end
			ST_READ: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_idx = cnt_q[KW-1:0];
				if (cnt_q == CNTW'((1 << KW) - 1)) begin
					state_d = ST_DRAIN;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				// wait for the last product to land in the accumulator
				if (cnt_q == CNTW'(1)) begin
					state_d = ST_DIV;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DIV: begin
				if (cnt_q == '0) begin
					cmd.div_load = 1'b1;
				end else begin
					cmd.div_step = 1'b1;
				end
				if (cnt_q == CNTW'(DIV_STEPS)) begin
					state_d = ST_OUT;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.last_col) begin
						state_d = ST_IDLE;
					end else begin
						cmd.next_col = 1'b1;
						state_d      = ST_READ;
						cnt_d        = '0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/gbdn_dp.sv @@
// Datapath: gray conversion, line store, position tracking, weighted sum and divider.
`default_nettype none
module gbdn_dp
	import gbdn_pkg::*;
#(
	parameter int IN_WIDTH   = IN_WIDTH_C,
	parameter int IN_HEIGHT  = IN_HEIGHT_C,
	parameter int OUT_WIDTH  = OUT_WIDTH_C,
	parameter int OUT_HEIGHT = OUT_HEIGHT_C
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	output sts_t      sts,
	input  wire pix_t pix,
	output logic      res_valid,
	output res_t      res_data,
	input  wire logic res_ready
);

	localparam int CW   = $clog2(IN_WIDTH);
	localparam int RW   = $clog2(IN_HEIGHT);
	localparam int XW   = $clog2(OUT_WIDTH);
	localparam int YW   = $clog2(OUT_HEIGHT);
	localparam int DX   = OUT_WIDTH - 1;
	localparam int DY   = OUT_HEIGHT - 1;
	localparam int FXW  = $clog2(DX);
	localparam int FYW  = $clog2(DY);
	localparam int QX   = (IN_WIDTH - 1) / DX;
	localparam int RX   = (IN_WIDTH - 1) % DX;
	localparam int QY   = (IN_HEIGHT - 1) / DY;
	localparam int RY   = (IN_HEIGHT - 1) % DY;
	localparam int WXW  = $clog2(2 * DX + 1);
	localparam int WYW  = $clog2(2 * DY + 1);
	localparam int WPW  = WXW + WYW;
	localparam int PRW  = GW + WPW;
	localparam int AW   = $clog2(4 * IN_WIDTH);
	localparam int DEN  = DX * DY * 16 * 255;
	localparam int DW   = $clog2(DEN + 1);
	localparam int SW   = DW + QW;
	// reciprocal estimate: top bits of the numerator times 2^(QW-1+SH)/DEN
	localparam int TW   = SW - QW + 1;
	localparam int SH   = DW + 2;
	localparam int RCW  = 20;
	localparam longint unsigned RECIP = (64'd1 << (QW - 1 + SH)) / 64'(DEN);

	// input position and next output row
	logic [CW-1:0]  in_col_q;
	logic [RW-1:0]  in_row_q;
	logic [YW-1:0]  nor_q;
	logic [RW-1:0]  y0_q;
	logic [FYW-1:0] fy_q;

	// row being emitted and column walk
	logic [YW-1:0]  ey_q;
	logic [RW-1:0]  ey0_q;
	logic [FYW-1:0] efy_q;
	logic [XW-1:0]  x_q;
	logic [CW-1:0]  x0_q;
	logic [FXW-1:0] fx_q;

	logic [CW-1:0]  col_e;
	logic [RW-1:0]  row_e;
	logic [YW-1:0]  nor_e;
	logic [RW-1:0]  y0_e;
	logic [FYW-1:0] fy_e;
	logic [RW+1:0]  lnr;
	logic           trigger;
	logic [GW-1:0]  gray;

	logic [FYW:0]   fy_sum;
	logic [YW-1:0]  nor_n;
	logic [RW-1:0]  y0_n;
	logic [FYW-1:0] fy_n;

	logic [FXW:0]   fx_sum;

	logic [1:0]     ky, kx;
	logic [RW+1:0]  ty;
	logic [CW+1:0]  tx;
	logic [RW-1:0]  rd_row;
	logic [CW-1:0]  rd_col;
	logic [WYW-1:0] wy;
	logic [WXW-1:0] wx;
	logic [AW-1:0]  wr_addr, rd_addr;
	logic [GW-1:0]  rd_data;

	logic [WPW-1:0] wp_s1;
	logic           v_s1;
	logic [PRW-1:0] prod_s2;
	logic           v_s2;
	logic [SW-1:0]  acc_q;

	logic [SW-1:0]     num_q;
	logic [QW-1:0]     quo_q;
	logic [SW-1:0]     num;
	logic [TW+RCW-1:0] est_prod;
	logic [SW-1:0]     back;
	logic [SW-1:0]     rem;
	logic              qbit;

	logic           res_valid_q;
	res_t           res_q;

	// frame start clears the position before the pixel is taken
	always_comb begin
		if (pix.frame_start) begin
			col_e = '0;
			row_e = '0;
			nor_e = '0;
			y0_e  = '0;
			fy_e  = '0;
		end else begin
			col_e = in_col_q;
			row_e = in_row_q;
			nor_e = nor_q;
			y0_e  = y0_q;
			fy_e  = fy_q;
		end
		lnr = (RW+2)'(y0_e) + (RW+2)'(2);
		if (lnr > (RW+2)'(IN_HEIGHT - 1)) begin
			lnr = (RW+2)'(IN_HEIGHT - 1);
		end
		trigger = (col_e == CW'(IN_WIDTH - 1)) && (lnr <= (RW+2)'(row_e));
		gray = WR_C * GW'(pix.red) + WG_C * GW'(pix.green) + WB_C * GW'(pix.blue);
	end

	// next output row position, kept as integer part and fraction over DY
	always_comb begin
		fy_sum = (FYW+1)'(fy_e) + (FYW+1)'(RY);
		if (nor_e == YW'(OUT_HEIGHT - 1)) begin
			nor_n = '0;
			y0_n  = '0;
			fy_n  = '0;
		end else if (fy_sum >= (FYW+1)'(DY)) begin
			nor_n = nor_e + 1'b1;
			y0_n  = y0_e + RW'(QY + 1);
			fy_n  = FYW'(fy_sum - (FYW+1)'(DY));
		end else begin
			nor_n = nor_e + 1'b1;
			y0_n  = y0_e + RW'(QY);
			fy_n  = FYW'(fy_sum);
		end
		fx_sum = (FXW+1)'(fx_q) + (FXW+1)'(RX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			nor_q    <= '0;
			y0_q     <= '0;
			fy_q     <= '0;
			x_q      <= '0;
			x0_q     <= '0;
			fx_q     <= '0;
		end else begin
			if (cmd.accept) begin
				if (col_e == CW'(IN_WIDTH - 1)) begin
					in_col_q <= '0;
					in_row_q <= (row_e == RW'(IN_HEIGHT - 1)) ? '0 : row_e + 1'b1;
				end else begin
					in_col_q <= col_e + 1'b1;
					in_row_q <= row_e;
				end
				if (trigger) begin
					nor_q <= nor_n;
					y0_q  <= y0_n;
					fy_q  <= fy_n;
					x_q   <= '0;
					x0_q  <= '0;
					fx_q  <= '0;
				end else begin
					nor_q <= nor_e;
					y0_q  <= y0_e;
					fy_q  <= fy_e;
				end
			end else if (cmd.next_col) begin
				x_q <= x_q + 1'b1;
				if (fx_sum >= (FXW+1)'(DX)) begin
					x0_q <= x0_q + CW'(QX + 1);
					fx_q <= FXW'(fx_sum - (FXW+1)'(DX));
				end else begin
					x0_q <= x0_q + CW'(QX);
					fx_q <= FXW'(fx_sum);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && trigger) begin
			ey_q  <= nor_e;
			ey0_q <= y0_e;
			efy_q <= fy_e;
		end
	end

	// window address with edge clamp, and the combined blur/bilinear weights
	always_comb begin
		ky = cmd.rd_idx[3:2];
		kx = cmd.rd_idx[1:0];
		ty = (RW+2)'(ey0_q) + (RW+2)'(ky);
		tx = (CW+2)'(x0_q) + (CW+2)'(kx);
		if (ty == '0) begin
			rd_row = '0;
		end else if (ty > (RW+2)'(IN_HEIGHT)) begin
			rd_row = RW'(IN_HEIGHT - 1);
		end else begin
			rd_row = RW'(ty - 1'b1);
		end
		if (tx == '0) begin
			rd_col = '0;
		end else if (tx > (CW+2)'(IN_WIDTH)) begin
			rd_col = CW'(IN_WIDTH - 1);
		end else begin
			rd_col = CW'(tx - 1'b1);
		end
		unique case (ky)
			2'd0: wy = WYW'(DY) - WYW'(efy_q);
			2'd1: wy = WYW'(2 * DY) - WYW'(efy_q);
			2'd2: wy = WYW'(DY) + WYW'(efy_q);
			default: wy = WYW'(efy_q);
		endcase
		unique case (kx)
			2'd0: wx = WXW'(DX) - WXW'(fx_q);
			2'd1: wx = WXW'(2 * DX) - WXW'(fx_q);
			2'd2: wx = WXW'(DX) + WXW'(fx_q);
			default: wx = WXW'(fx_q);
		endcase
		rd_addr = AW'(rd_row[1:0]) * AW'(IN_WIDTH) + AW'(rd_col);
		wr_addr = AW'(row_e[1:0]) * AW'(IN_WIDTH) + AW'(col_e);
	end

	gbdn_ram #(
		.WIDTH (GW),
		.DEPTH (4 * IN_WIDTH)
	) u_line_store (
		.clk     (clk),
		.wr_en   (cmd.accept),
		.wr_addr (wr_addr),
		.wr_data (gray),
		.rd_en   (cmd.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			if (cmd.div_load) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + SW'(prod_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		wp_s1   <= WPW'(wy) * WPW'(wx);
		prod_s2 <= PRW'(rd_data) * PRW'(wp_s1);
	end

	// quotient estimate by reciprocal multiplication is low by at most one;
	// the correction step adds it back when the remainder still covers DEN
	always_comb begin
		num      = acc_q + SW'(DEN / 2);
		est_prod = (TW+RCW)'(num[SW-1:QW-1]) * (TW+RCW)'(RECIP);
		back     = SW'(quo_q) * SW'(DEN);
		rem      = num_q - back;
		qbit     = rem >= SW'(DEN);
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			num_q <= num;
			quo_q <= QW'(est_prod >> SH);
		end else if (cmd.div_step && qbit) begin
			quo_q <= quo_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q.feature    <= quo_q[QW-1] ? 16'hFFFF : quo_q[15:0];
			res_q.out_col    <= 6'(x_q);
			res_q.out_row    <= 6'(ey_q);
			res_q.row_done   <= (x_q == XW'(OUT_WIDTH - 1));
			res_q.frame_done <= (x_q == XW'(OUT_WIDTH - 1)) &&
				(ey_q == YW'(OUT_HEIGHT - 1));
		end
	end

	assign res_valid    = res_valid_q;
	assign res_data     = res_q;
	assign sts.trigger  = trigger;
	assign sts.out_free = !res_valid_q || res_ready;
	assign sts.last_col = (x_q == XW'(OUT_WIDTH - 1));

endmodule
`default_nettype wire

@@ rtl/core/gray_blur_downscale_normalizer.sv @@
// Top level: RGB pixel stream in, blurred, downscaled, normalized gray features out.
//
//   channel   dir   payload                                            request
//   pixel     in    red, green, blue, frame_start                      one pixel
//   result    out   feature, out_col, out_row, row_done, frame_done    one feature
//
// A pixel without an output row due is taken and the controller stays idle.
// The pixel that completes the last source row an output row needs starts that
// row: each feature walks a 4x4 window through the single read port of the line
// store, drains the multiply pipeline, runs the reciprocal divider with one
// correction and hands off; pixel intake holds until the row is done. The
// result register lets the next feature compute while one waits.
// arst_n clears positions and handshake state; the line store is not cleared.
`default_nettype none
module gray_blur_downscale_normalizer
	import gbdn_pkg::*;
#(
	parameter int IN_WIDTH   = IN_WIDTH_C,
	parameter int IN_HEIGHT  = IN_HEIGHT_C,
	parameter int OUT_WIDTH  = OUT_WIDTH_C,
	parameter int OUT_HEIGHT = OUT_HEIGHT_C
) (
	input wire logic        clk,
	input wire logic        arst_n,
	gbdn_stream_if.sink     pixel,
	gbdn_stream_if.source   result
);

	cmd_t cmd;
	sts_t sts;
	logic pix_ready;
	logic res_valid;
	res_t res_data;
	pix_t pix;

	assign pix          = pixel.data;
	assign pixel.ready  = pix_ready;
	assign result.valid = res_valid;
	assign result.data  = res_data;

	gbdn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pixel.valid),
		.pix_ready (pix_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gbdn_dp #(
		.IN_WIDTH   (IN_WIDTH),
		.IN_HEIGHT  (IN_HEIGHT),
		.OUT_WIDTH  (OUT_WIDTH),
		.OUT_HEIGHT (OUT_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.pix       (pix),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_ready (result.ready)
	);

endmodule
`default_nettype wire
